@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SMR_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define SMR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SMR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/smr_pkg.sv @@
// ---------------------------------------------------------------------------
// smr_pkg
// Widths, codes and shared types of the sorted multiset rank query block.
// ---------------------------------------------------------------------------
package smr_pkg;

    // Store geometry
    localparam int CAPACITY = 256;
    localparam int MAX_RANK = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int VAL_W  = 60;
    localparam int OP_W   = 2;
    localparam int RANK_W = 3;
    localparam int STAT_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_BELOW  = 2'd1;
    localparam logic [OP_W-1:0] OP_ABOVE  = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [OP_W-1:0]   t_opcode;
    typedef logic [RANK_W-1:0] t_rank;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [CNT_W-1:0]  t_count;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL
    } t_state;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic  cmp_en;
        logic  ins_en;
        logic  q_below;
        logic  q_above;
        t_rank rank;
    } t_cell_ctrl;

endpackage

@@ rtl/smr_if.sv @@
// ---------------------------------------------------------------------------
// smr_in_if / smr_out_if
// Valid/ready channels carrying request and response items.
// ---------------------------------------------------------------------------
interface smr_in_if;
    import smr_pkg::*;

    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_value  key_value;
    t_rank   rank;

    modport source (output valid, output opcode, output key_value, output rank, input ready);
    modport sink   (input valid, input opcode, input key_value, input rank, output ready);
endinterface

interface smr_out_if;
    import smr_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_value  found_value;

    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);
endinterface

@@ rtl/smr_cell.sv @@
// ---------------------------------------------------------------------------
// smr_cell
// One slot of the sorted chain: holds a value, compares it with the key,
// shifts in from the left neighbour on insert and flags a query hit.
// ---------------------------------------------------------------------------
module smr_cell (
    input  logic                        i_clk,
    input  smr_pkg::t_cell_ctrl         i_ctrl,
    input  smr_pkg::t_value             i_key,
    input  smr_pkg::t_value             i_left_value,
    input  logic                        i_left_le,
    input  logic                        i_occupied,
    input  logic [smr_pkg::MAX_RANK:0]  i_le_win,
    input  logic [smr_pkg::MAX_RANK:0]  i_lt_win,
    output smr_pkg::t_value             o_value,
    output smr_pkg::t_value             o_pick,
    output logic                        o_le,
    output logic                        o_lt,
    output logic                        o_hit
);
    import smr_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   r_le;
    logic   n_le;
    logic   r_lt;
    logic   n_lt;
    logic   w_hit;

    // Compare against the key, then shift right of the insertion point
    always_comb begin
        n_value = r_value;
        n_le    = r_le;
        n_lt    = r_lt;
        if (i_ctrl.cmp_en) begin
            n_le = i_occupied && (r_value <= i_key);
            n_lt = i_occupied && (r_value < i_key);
        end
        if (i_ctrl.ins_en && !r_le) begin
            n_value = i_left_le ? i_key : i_left_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_le    <= n_le;
        r_lt    <= n_lt;
    end

    // Hit: this slot sits exactly rank places from the compare boundary.
    // le_win[j] is the flag j slots to the right, lt_win[j] j slots to the left.
    always_comb begin
        w_hit = 1'b0;
        for (int k = 1; k <= MAX_RANK; k++) begin
            if (i_ctrl.rank == RANK_W'(k)) begin
                if (i_ctrl.q_below) begin
                    w_hit = i_le_win[k-1] && !i_le_win[k];
                end else if (i_ctrl.q_above) begin
                    w_hit = i_occupied && i_lt_win[k] && !i_lt_win[k-1];
                end
            end
        end
    end

    assign o_value = r_value;
    assign o_pick  = w_hit ? r_value : '0;
    assign o_le    = r_le;
    assign o_lt    = r_lt;
    assign o_hit   = w_hit;

endmodule

@@ rtl/sorted_multiset_rank_query.sv @@
// ---------------------------------------------------------------------------
// sorted_multiset_rank_query
// Sorted multiset in a chain of compare cells with insert and k-th
// neighbour queries.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries opcode, key_value and rank; o_rsp returns status and
//   found_value, one response for every request, in order.
//   Insert places the value after any equal ones; a full store drops it
//   with status full. Query below returns the rank-th largest value at most
//   the key, query above the rank-th smallest value at least the key.
//   A transferred request is compared by every cell in the compare state;
//   the select state then does the insert shift or result pick and loads
//   the response into the output register. A new request is taken in idle
//   or in select once the output register is free.
//   Reset empties the store (count to zero) at once; no clearing pass.
//   While the receiver stalls, the response waits in the output register;
//   the next request is still taken and compared, and its select cycle
//   holds until the output register frees.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_multiset_rank_query (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smr_in_if.sink    i_req,
    smr_out_if.source o_rsp
);
    import smr_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_opcode    r_op;
    t_value     r_key;
    t_rank      r_rank;
    t_count     r_count;
    t_count     n_count;
    logic       r_out_valid;
    t_status    r_status;
    t_value     r_value;

    t_cell_ctrl w_ctrl;
    logic       w_accept;
    logic       w_out_free;
    logic       w_ins_ok;
    logic       w_found;
    t_value     w_pick;

    logic [CAPACITY-1:0]          w_le;
    logic [CAPACITY-1:0]          w_lt;
    logic [CAPACITY-1:0]          w_hit;
    logic [CAPACITY-1:0]          w_occ;
    logic [CAPACITY+MAX_RANK-1:0] w_le_ext;
    logic [CAPACITY+MAX_RANK-1:0] w_lt_ext;
    logic [MAX_RANK:0]            w_le_win [CAPACITY];
    logic [MAX_RANK:0]            w_lt_win [CAPACITY];
    t_value                       w_cell_value [CAPACITY];
    t_value                       w_cell_pick  [CAPACITY];

    // Handshake
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) || ((r_state == S_SEL) && w_out_free);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_ins_ok    = (r_op == OP_INSERT) && (r_count != CNT_W'(CAPACITY));

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        w_ctrl  = '{cmp_en: (r_state == S_CMP),
                    ins_en: 1'b0,
                    q_below: (r_op == OP_BELOW),
                    q_above: (r_op == OP_ABOVE),
                    rank: r_rank};
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_SEL;
            end
            S_SEL: begin
                if (w_out_free) begin
                    w_ctrl.ins_en = w_ins_ok;
                    if (w_ins_ok) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = w_accept ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Hold the request under work
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_req.opcode;
            r_key  <= i_req.key_value;
            r_rank <= i_req.rank;
        end
    end

    // Pad the flag rows: everything left of slot 0 counts as below the key,
    // nothing right of the last slot does
    assign w_le_ext = {{MAX_RANK{1'b0}}, w_le};
    assign w_lt_ext = {w_lt, {MAX_RANK{1'b1}}};

    // Chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_occ[g]    = CNT_W'(g) < r_count;
        assign w_le_win[g] = w_le_ext[g+MAX_RANK:g];
        for (genvar j = 0; j <= MAX_RANK; j++) begin : g_win
            assign w_lt_win[g][j] = w_lt_ext[g-j+MAX_RANK];
        end

        if (g == 0) begin : g_head
            smr_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_key        (r_key),
                .i_left_value (r_key),
                .i_left_le    (1'b1),
                .i_occupied   (w_occ[g]),
                .i_le_win     (w_le_win[g]),
                .i_lt_win     (w_lt_win[g]),
                .o_value      (w_cell_value[g]),
                .o_pick       (w_cell_pick[g]),
                .o_le         (w_le[g]),
                .o_lt         (w_lt[g]),
                .o_hit        (w_hit[g])
            );
        end else begin : g_body
            smr_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_key        (r_key),
                .i_left_value (w_cell_value[g-1]),
                .i_left_le    (w_le[g-1]),
                .i_occupied   (w_occ[g]),
                .i_le_win     (w_le_win[g]),
                .i_lt_win     (w_lt_win[g]),
                .o_value      (w_cell_value[g]),
                .o_pick       (w_cell_pick[g]),
                .o_le         (w_le[g]),
                .o_lt         (w_lt[g]),
                .o_hit        (w_hit[g])
            );
        end
    end

    // Merge the picks; at most one cell hits
    always_comb begin
        w_pick  = '0;
        w_found = 1'b0;
        for (int c = 0; c < CAPACITY; c++) begin
            w_pick  = w_pick | w_cell_pick[c];
            w_found = w_found | w_hit[c];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_SEL) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SEL) && w_out_free) begin
            if (r_op == OP_INSERT) begin
                r_status <= w_ins_ok ? ST_OK : ST_FULL;
                r_value  <= '0;
            end else begin
                r_status <= w_found ? ST_OK : ST_NOT_FOUND;
                r_value  <= w_pick;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.found_value = r_value;

    // Checks
    `SMR_ASSERT(a_count_range, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `SMR_ASSERT_IMP(a_one_hit, r_state == S_SEL, $onehot0(w_hit), "more than one cell hit")
    `SMR_ASSERT_NXT(a_count_hold, r_state != S_SEL, $stable(r_count), "count moved outside select")
    `SMR_ASSERT_IMP(a_no_take_in_cmp, r_state == S_CMP, !i_req.ready, "request taken in compare")

endmodule
